// File: hw/rtl/wbl_pkg.sv
// Package for the wavetable bilinear lookup unit: table geometry, field widths,
// operation codes and the fixed-point blend helpers.
// Depends on nothing; used by the top level and the checker of the block.
package wbl_pkg;

   // Table geometry and sample width.
   localparam int TABLE_LENGTH = 256;
   localparam int SLICE_COUNT  = 8;
   localparam int SAMPLE_BITS  = 16;

   localparam int IDX_BITS  = $clog2(TABLE_LENGTH);
   localparam int SLC_BITS  = $clog2(SLICE_COUNT);
   localparam int MEM_DEPTH = TABLE_LENGTH * SLICE_COUNT;
   localparam int ADDR_BITS = $clog2(MEM_DEPTH);
   localparam int WIDE_BITS = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;
   localparam int PROD_BITS = SAMPLE_BITS + 18;

   // Fixed widths of the request and response fields.
   localparam int PHASE_BITS    = 32;
   localparam int SHAPE_BITS    = 16;
   localparam int SEL_BITS      = 6;
   localparam int POS_BITS      = 12;
   localparam int VALUE_BITS    = 16;
   localparam int WAVE_BITS     = 16;
   localparam int FRAC_BITS     = 16;
   localparam int REQ_DATA_BITS =
      ((PHASE_BITS + SHAPE_BITS + SEL_BITS + POS_BITS + VALUE_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = WAVE_BITS;

   // Result queue: holds finished lookups while the receiver stalls.
   localparam int OUT_DEPTH    = 4;
   localparam int OUT_PTR_BITS = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_BITS = $clog2(OUT_DEPTH + 1);

   typedef enum logic {
      OP_LOOKUP = 1'b0,
      OP_WRITE  = 1'b1
   } op_type;

   // Which of the three remaining samples the fetch sequencer reads next.
   typedef enum logic [1:0] {
      FETCH_IDLE = 2'd0,
      FETCH_S01  = 2'd1,
      FETCH_S10  = 2'd2,
      FETCH_S11  = 2'd3
   } fetch_type;

   typedef logic [ADDR_BITS-1:0]          addr_type;
   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [PROD_BITS-1:0]   prod_type;

   // Linear memory address of one sample in one slice.
   function automatic addr_type mem_addr(input logic [SEL_BITS-1:0] slice,
                                         input logic [POS_BITS-1:0] pos);
      int unsigned lin;
      lin = 32'(slice) * 32'(TABLE_LENGTH) + 32'(pos);
      return lin[ADDR_BITS-1:0];
   endfunction

   // A written value keeps its low bits when the store is narrow and is
   // sign-extended when it is wide.
   function automatic sample_type to_sample(input logic [VALUE_BITS-1:0] v);
      logic signed [WIDE_BITS-1:0] x;
      x = WIDE_BITS'($signed(v));
      return x[SAMPLE_BITS-1:0];
   endfunction

   // The response carries the low 16 bits of the sign-extended sample.
   function automatic logic [WAVE_BITS-1:0] to_wave(input sample_type y);
      logic signed [WIDE_BITS-1:0] x;
      x = WIDE_BITS'(y);
      return x[WAVE_BITS-1:0];
   endfunction

   // First half of a blend: the weighted difference w * (b - a).
   function automatic prod_type blend_mult(input sample_type b, input sample_type a,
                                           input logic [FRAC_BITS-1:0] w);
      logic signed [SAMPLE_BITS:0]   diff;
      logic signed [FRAC_BITS:0]     weight;
      prod_type                      prod;
      diff   = (SAMPLE_BITS+1)'(b) - (SAMPLE_BITS+1)'(a);
      weight = {1'b0, w};
      prod   = diff * weight;
      return prod;
   endfunction

   // Second half of a blend: a plus the floored product. The result lies
   // between a and b, so it always fits a sample.
   function automatic sample_type blend_sum(input sample_type a, input prod_type prod);
      prod_type                      shifted;
      logic signed [SAMPLE_BITS+1:0] sum;
      shifted = prod >>> FRAC_BITS;
      sum     = (SAMPLE_BITS+2)'(a) + (SAMPLE_BITS+2)'(shifted);
      return sum[SAMPLE_BITS-1:0];
   endfunction

endpackage

// File: hw/rtl/wavetable_bilinear_lookup_unit.sv
// Top level of the wavetable bilinear lookup unit: fetch sequencer, blend
// pipeline and result queue around one single-port sample memory.
// Depends on wbl_pkg and wbl_ram.
//
// Usage. Requests arrive on the req_ stream. req_tuser selects the kind: a
// write stores one sample in the table, a lookup returns one blended sample
// on the rsp_ stream; writes produce no response. Responses leave in request
// order.
// Ordering: a lookup's result enters the result queue when it leaves the blend
// pipeline. A write lands in the memory in the cycle of its acceptance, so
// any later lookup sees it.
// Port use: a write uses the memory port only in its own cycle, so the next
// request can be taken at once while the queue limit below allows; a lookup
// holds the single memory port for its four sample reads, req_tready low.
// Stalls: up to four lookups may be accepted and not yet delivered; while the
// receiver holds rsp_tready low the results wait in a four-entry queue and
// req_tready drops once four are outstanding. Writes are held by that limit
// as well, since req_tready does not look at the request kind.
// Reset clears the sequencer, the pipeline and the queue. The sample memory
// is not cleared: its entries are undefined until written.
module wavetable_bilinear_lookup_unit (
   input  logic                               clock,
   input  logic                               reset,
   // Request stream.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // tdata from bit 0: phase[31:0], shape[47:32], slice_select[53:48],
   // sample_position[65:54], sample_value[81:66], zeros[87:82].
   input  logic [wbl_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // tuser: operation (0 = lookup, 1 = write).
   input  logic                               req_tuser,
   // Response stream.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // tdata from bit 0: wave_value[15:0].
   output logic [wbl_pkg::RSP_DATA_BITS-1:0]  rsp_tdata
);
   import wbl_pkg::*;

   // Request fields.
   logic [PHASE_BITS-1:0]        req_phase;
   logic signed [SHAPE_BITS-1:0] req_shape;
   logic [SEL_BITS-1:0]          req_slice_select;
   logic [POS_BITS-1:0]          req_sample_position;
   logic [VALUE_BITS-1:0]        req_sample_value;

   assign req_phase           = req_tdata[31:0];
   assign req_shape           = req_tdata[47:32];
   assign req_slice_select    = req_tdata[53:48];
   assign req_sample_position = req_tdata[65:54];
   assign req_sample_value    = req_tdata[81:66];

   logic req_fire;
   logic lookup_fire;
   logic write_fire;
   logic write_in_range;

   assign req_fire    = req_tvalid && req_tready;
   assign lookup_fire = req_fire && (op_type'(req_tuser) == OP_LOOKUP);
   assign write_fire  = req_fire && (op_type'(req_tuser) == OP_WRITE);
   assign write_in_range =
      ((SEL_BITS+1)'(req_slice_select) < (SEL_BITS+1)'(SLICE_COUNT)) &&
      ((POS_BITS+1)'(req_sample_position) < (POS_BITS+1)'(TABLE_LENGTH));

   // Phase scaled by the table length: integer part picks the sample, the
   // next 16 bits weight the blend along phase.
   logic [PHASE_BITS+IDX_BITS:0] phase_scaled;
   logic [IDX_BITS-1:0]          idx0;
   logic [IDX_BITS-1:0]          idx1;
   logic [FRAC_BITS-1:0]         phase_frac;

   assign phase_scaled = (PHASE_BITS+IDX_BITS+1)'(req_phase) *
                         (PHASE_BITS+IDX_BITS+1)'(TABLE_LENGTH);
   assign idx0         = phase_scaled[PHASE_BITS +: IDX_BITS];
   assign phase_frac   = phase_scaled[PHASE_BITS-1 -: FRAC_BITS];
   assign idx1         = (idx0 == IDX_BITS'(TABLE_LENGTH - 1)) ? '0 : idx0 + IDX_BITS'(1);

   // Shape offset to [0, 1) and scaled by the slice count; the top slice
   // blends back into slice zero.
   logic [SHAPE_BITS-1:0]        shape_offset;
   logic [SHAPE_BITS+SLC_BITS:0] shape_scaled;
   logic [SLC_BITS-1:0]          slc0;
   logic [SLC_BITS-1:0]          slc1;
   logic [FRAC_BITS-1:0]         shape_frac;

   assign shape_offset = {~req_shape[SHAPE_BITS-1], req_shape[SHAPE_BITS-2:0]};
   assign shape_scaled = (SHAPE_BITS+SLC_BITS+1)'(shape_offset) *
                         (SHAPE_BITS+SLC_BITS+1)'(SLICE_COUNT);
   assign slc0         = shape_scaled[SHAPE_BITS +: SLC_BITS];
   assign shape_frac   = shape_scaled[FRAC_BITS-1:0];
   assign slc1         = (slc0 == SLC_BITS'(SLICE_COUNT - 1)) ? '0 : slc0 + SLC_BITS'(1);

   // Fetch sequencer: the first sample is read in the cycle of acceptance,
   // the other three in the following cycles.
   logic      busy_ff;
   logic      busy_in;
   fetch_type step_ff;
   fetch_type step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= FETCH_IDLE;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (lookup_fire) begin
         busy_in = 1'b1;
         step_in = FETCH_S01;
      end else if (busy_ff) begin
         case (step_ff)
            FETCH_S01: step_in = FETCH_S10;
            FETCH_S10: step_in = FETCH_S11;
            FETCH_S11: begin
               busy_in = 1'b0;
               step_in = FETCH_IDLE;
            end
            default: begin
               busy_in = 1'b0;
               step_in = FETCH_IDLE;
            end
         endcase
      end
   end

   // Addresses of the three later fetches and the two weights.
   addr_type             addr01_ff;
   addr_type             addr10_ff;
   addr_type             addr11_ff;
   logic [FRAC_BITS-1:0] phase_frac_ff;
   logic [FRAC_BITS-1:0] shape_frac_ff;

   always_ff @(posedge clock) begin
      if (lookup_fire) begin
         addr01_ff     <= mem_addr(SEL_BITS'(slc0), POS_BITS'(idx1));
         addr10_ff     <= mem_addr(SEL_BITS'(slc1), POS_BITS'(idx0));
         addr11_ff     <= mem_addr(SEL_BITS'(slc1), POS_BITS'(idx1));
         phase_frac_ff <= phase_frac;
         shape_frac_ff <= shape_frac;
      end
   end

   // Memory port: a write or the first fetch on acceptance, else the
   // sequencer's fetch. Accesses never overlap, so no forwarding is needed.
   logic       ram_we;
   addr_type   ram_addr;
   sample_type ram_wdata;
   sample_type ram_rdata;

   always_comb begin
      ram_we    = 1'b0;
      ram_addr  = mem_addr(SEL_BITS'(slc0), POS_BITS'(idx0));
      ram_wdata = to_sample(req_sample_value);
      if (write_fire) begin
         ram_we   = write_in_range;
         ram_addr = mem_addr(req_slice_select, req_sample_position);
      end else if (busy_ff) begin
         case (step_ff)
            FETCH_S01: ram_addr = addr01_ff;
            FETCH_S10: ram_addr = addr10_ff;
            FETCH_S11: ram_addr = addr11_ff;
            default:   ram_addr = addr01_ff;
         endcase
      end
   end

   wbl_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (MEM_DEPTH)
   ) u_wave_memory (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wdata),
      .rd_data (ram_rdata)
   );

   // Stage markers of the blend pipeline; each marker bit passes an accepted
   // lookup on to the next stage.
   logic [7:1] stage_ff;
   logic [7:1] stage_in;

   assign stage_in = {stage_ff[6:1], lookup_fire};

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   // Blend pipeline: along phase in the near slice, along phase in the far
   // slice, then across shape. Each blend is a registered product followed
   // by a floored add.
   sample_type           s00_ff;
   sample_type           s10_ff;
   prod_type             prod_a_ff;
   prod_type             prod_b_ff;
   prod_type             prod_c_ff;
   sample_type           near_ff;
   sample_type           far_ff;
   logic [FRAC_BITS-1:0] shape_frac_hold_ff;

   always_ff @(posedge clock) begin
      if (stage_ff[1]) begin
         s00_ff <= ram_rdata;
      end
      if (stage_ff[2]) begin
         prod_a_ff <= blend_mult(ram_rdata, s00_ff, phase_frac_ff);
      end
      if (stage_ff[3]) begin
         s10_ff  <= ram_rdata;
         near_ff <= blend_sum(s00_ff, prod_a_ff);
      end
      if (stage_ff[4]) begin
         prod_b_ff          <= blend_mult(ram_rdata, s10_ff, phase_frac_ff);
         shape_frac_hold_ff <= shape_frac_ff;
      end
      if (stage_ff[5]) begin
         far_ff <= blend_sum(s10_ff, prod_b_ff);
      end
      if (stage_ff[6]) begin
         prod_c_ff <= blend_mult(far_ff, near_ff, shape_frac_hold_ff);
      end
   end

   logic [WAVE_BITS-1:0] wave_value;

   assign wave_value = to_wave(blend_sum(near_ff, prod_c_ff));

   // Result queue and the count of lookups not yet delivered.
   logic [WAVE_BITS-1:0]    queue_ff [OUT_DEPTH];
   logic [OUT_PTR_BITS-1:0] wr_ptr_ff;
   logic [OUT_PTR_BITS-1:0] rd_ptr_ff;
   logic [OUT_CNT_BITS-1:0] fill_ff;
   logic [OUT_CNT_BITS-1:0] fill_in;
   logic [OUT_CNT_BITS-1:0] pending_ff;
   logic [OUT_CNT_BITS-1:0] pending_in;
   logic                    push;
   logic                    pop;

   assign push = stage_ff[7];
   assign pop  = rsp_tvalid && rsp_tready;

   always_comb begin
      fill_in    = fill_ff;
      pending_in = pending_ff;
      if (push && !pop) begin
         fill_in = fill_ff + OUT_CNT_BITS'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - OUT_CNT_BITS'(1);
      end
      if (lookup_fire && !pop) begin
         pending_in = pending_ff + OUT_CNT_BITS'(1);
      end else if (pop && !lookup_fire) begin
         pending_in = pending_ff - OUT_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         fill_ff    <= '0;
         pending_ff <= '0;
      end else begin
         fill_ff    <= fill_in;
         pending_ff <= pending_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + OUT_PTR_BITS'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + OUT_PTR_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= wave_value;
      end
   end

   // A request is taken when the memory port is free and the queue has room
   // for another lookup result.
   assign req_tready = !busy_ff && (pending_ff != OUT_CNT_BITS'(OUT_DEPTH));
   assign rsp_tvalid = (fill_ff != '0);
   assign rsp_tdata  = queue_ff[rd_ptr_ff];

endmodule

// File: hw/rtl/wbl_ram.sv
// Generic single-port synchronous RAM with a registered read port.
// Depends on nothing; used for the sample memory of the lookup unit.
module wbl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // One access a cycle: a write, or a read whose data appears next cycle; a write also reads the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end

endmodule

// File: hw/rtl/wbl_checker.sv
// Port-level checks for the wavetable bilinear lookup unit, bound to its top
// level. Depends on wbl_pkg and wavetable_bilinear_lookup_unit.
module wbl_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic [wbl_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   input logic                               req_tuser,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [wbl_pkg::RSP_DATA_BITS-1:0]  rsp_tdata
);
   import wbl_pkg::*;

   logic lookup_fire;
   logic write_fire;

   assign lookup_fire = req_tvalid && req_tready && (op_type'(req_tuser) == OP_LOOKUP);
   assign write_fire  = req_tvalid && req_tready && (op_type'(req_tuser) == OP_WRITE);

   // Reset empties the result queue.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // A lookup holds the memory port for its three further fetches.
   a_lookup_port: assert property (@(posedge clock) disable iff (reset)
      lookup_fire |=> !req_tready ##1 !req_tready ##1 !req_tready)
      else $error("request taken while lookup fetches are in progress");

   // A write leaves the port free for the next request.
   a_write_free: assert property (@(posedge clock) disable iff (reset)
      write_fire |=> req_tready)
      else $error("write held the request port");

   // A stalled response stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

endmodule

bind wavetable_bilinear_lookup_unit wbl_checker u_wbl_checker (.*);
